// File: rtl/core/etfp_pkg.sv
// ============================================================================
// etfp_pkg - shared types and constants for the escape-time point core
// Fixed-point widths, payload structs, register map and sequencer states.
// ============================================================================
`default_nettype none

package etfp_pkg;

    // Fixed-point format of the input fields and of z, c.
    localparam int F          = 28;           // fraction bits
    localparam int COUNT_BITS = 16;           // iteration counter width
    localparam int IN_W       = 32;           // input field width
    localparam int R2_W       = 42;           // escape radius field width
    localparam int MAX_ITER_W = 16;           // max_iterations register width

    // Datapath widths. |z| stays below 2^35 (LSB units) while iterating,
    // and all pre-test operands stay below 2^34.
    localparam int MAG_W   = 36;              // operand magnitude
    localparam int Z_W     = MAG_W + 1;       // signed operand / state
    localparam int HALF_W  = MAG_W / 2;       // multiplier B slice
    localparam int ACC_W   = 2 * MAG_W;       // full product
    localparam int PMAG_W  = ACC_W - F;       // product magnitude after shift
    localparam int SP_W    = PMAG_W + 1;      // signed product
    localparam int SUM_W   = SP_W + 2;        // sums of products, with headroom

    // Constants in LSB units.
    localparam logic signed [IN_W-1:0]  FOUR_IN    = IN_W'(1) <<< (F + 2);
    localparam logic signed [Z_W-1:0]   ONE_Z      = Z_W'(1) <<< F;
    localparam logic signed [Z_W-1:0]   QUARTER_Z  = Z_W'(1) <<< (F - 2);
    localparam logic signed [SUM_W-1:0] ESC_LIMIT  = SUM_W'(1) <<< (F + 6);
    localparam logic signed [SUM_W-1:0] BULB_LIMIT = SUM_W'(1) <<< (F - 4);
    localparam logic signed [SUM_W-1:0] R2_MAX     = (SUM_W'(1) <<< R2_W) - SUM_W'(1);

    // APB register map (register index = paddr[2]).
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_MODE     = 1'b1;
    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = MAX_ITER_W'(255);

    typedef struct packed {
        logic signed [IN_W-1:0] start_real;
        logic signed [IN_W-1:0] start_imag;
        logic signed [IN_W-1:0] const_real;
        logic signed [IN_W-1:0] const_imag;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic [R2_W-1:0]       escape_radius_sq;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PT_CY2,
        ST_PT_CXQ2,
        ST_PT_Q,
        ST_PT_QQ,
        ST_PT_BULB,
        ST_PT_BTEST,
        ST_ZX2,
        ST_ZY2,
        ST_XY,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/escape_time_fractal_point_core.sv
// With the pre-test enabled, a cardioid/bulb test runs before the iterations.
// One point at a time: a new point is taken only while the sequencer is idle, and
// the iteration speed is set by the single 36x18 multiplier (two passes per
// product, three products per iteration).
// Reset (i_rst_n low, synchronous): sequencer idle, output empty, max_iterations = 255.
// ============================================================================
// escape_time_fractal_point_core - escape-time iteration of one point
// Runs z = z*z + c in Q4.28 fixed point on one shared multiplier, with an
// optional main-cardioid / period-2-bulb pre-test for Mandelbrot mode.
// ============================================================================
`default_nettype none

module escape_time_fractal_point_core
    import etfp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    logic                     r_phase, n_phase;     // multiplier pass: 0 = low B slice
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;
    logic [MAX_ITER_W-1:0]    r_max_iter, n_max_iter;
    logic                     r_mode, n_mode;

    logic signed [Z_W-1:0]    r_zx, n_zx;
    logic signed [Z_W-1:0]    r_zy, n_zy;
    logic signed [Z_W-1:0]    r_cx, n_cx;
    logic signed [Z_W-1:0]    r_cy, n_cy;
    logic [COUNT_BITS-1:0]    r_limit, n_limit;
    logic [COUNT_BITS-1:0]    r_count, n_count;
    logic [ACC_W-1:0]         r_acc, n_acc;         // product accumulator
    logic                     r_neg, n_neg;         // sign of product in r_acc
    logic signed [SP_W-1:0]   r_cy2, n_cy2;
    logic signed [Z_W-1:0]    r_q, n_q;             // q
    logic signed [Z_W-1:0]    r_qc, n_qc;           // q + (cx - 1/4)
    logic signed [SP_W-1:0]   r_sq_x, n_sq_x;
    logic signed [SP_W-1:0]   r_sq_y, n_sq_y;
    logic [R2_W-1:0]          r_r2, n_r2;
    logic                     r_escaped, n_escaped;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_xfer, out_free, cfg_wr;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_MAX_ITER: prdata = PDATA_W'(r_max_iter);
            REG_MODE:     prdata = PDATA_W'(r_mode);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier: |a| (36 bits) x 18-bit slice of |b|, two passes
    // accumulated into a 72-bit exact product.
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0]    cxq, cxp1;
    logic signed [Z_W-1:0]    op_a, op_b;
    logic signed [Z_W-1:0]    neg_a, neg_b;
    logic [MAG_W-1:0]         mag_a, mag_b;
    logic [HALF_W-1:0]        b_slice;
    logic [MAG_W+HALF_W-1:0]  part;
    logic                     is_mul;

    assign cxq  = r_cx - QUARTER_Z;
    assign cxp1 = r_cx + ONE_Z;

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        is_mul = 1'b1;
        case (r_state)
            ST_PT_CY2:  begin op_a = r_cy; op_b = r_cy; end
            ST_PT_CXQ2: begin op_a = cxq;  op_b = cxq;  end
            ST_PT_QQ:   begin op_a = r_q;  op_b = r_qc; end
            ST_PT_BULB: begin op_a = cxp1; op_b = cxp1; end
            ST_ZX2:     begin op_a = r_zx; op_b = r_zx; end
            ST_ZY2:     begin op_a = r_zy; op_b = r_zy; end
            ST_XY:      begin op_a = r_zx; op_b = r_zy; end
            default:    is_mul = 1'b0;
        endcase
    end

    assign neg_a   = -op_a;
    assign neg_b   = -op_b;
    assign mag_a   = op_a[Z_W-1] ? neg_a[MAG_W-1:0] : op_a[MAG_W-1:0];
    assign mag_b   = op_b[Z_W-1] ? neg_b[MAG_W-1:0] : op_b[MAG_W-1:0];
    assign b_slice = r_phase ? mag_b[MAG_W-1:HALF_W] : mag_b[HALF_W-1:0];
    assign part    = mag_a * b_slice;

    // Finished product, truncated toward zero to F fraction bits.
    logic [PMAG_W-1:0]      prod_mag;
    logic signed [SP_W-1:0] prod_pos, prod;

    assign prod_mag = r_acc[ACC_W-1:F];
    assign prod_pos = signed'({1'b0, prod_mag});
    assign prod     = r_neg ? -prod_pos : prod_pos;

    // ------------------------------------------------------------------
    // Decisions
    // ------------------------------------------------------------------
    logic                     c_far;
    logic signed [SUM_W-1:0]  q_sum, qc_sum, lhs, bulb_sum, r2_sum, nx_sum, ny_sum;
    logic                     in_cardioid, in_bulb, escape, last_iter;
    logic [R2_W-1:0]          r2_sat;

    // Constant far outside: neither region test is evaluated.
    assign c_far = (i_in_data.const_real >= FOUR_IN) || (i_in_data.const_real <= -FOUR_IN)
                || (i_in_data.const_imag >= FOUR_IN) || (i_in_data.const_imag <= -FOUR_IN);

    // q = (cx - 1/4)^2 + cy^2; cardioid: 4*q*(q + cx - 1/4) < cy^2
    assign q_sum       = SUM_W'(prod) + SUM_W'(r_cy2);
    assign qc_sum      = q_sum + SUM_W'(cxq);
    assign lhs         = SUM_W'(prod) <<< 2;
    assign in_cardioid = lhs < SUM_W'(r_cy2);
    // bulb: (cx + 1)^2 + cy^2 < 1/16
    assign bulb_sum    = SUM_W'(prod) + SUM_W'(r_cy2);
    assign in_bulb     = bulb_sum < BULB_LIMIT;

    // |z|^2 check, taken while zy^2 sits in the accumulator.
    assign r2_sum = SUM_W'(r_sq_x) + SUM_W'(prod);
    assign escape = r2_sum >= ESC_LIMIT;
    assign r2_sat = (r2_sum > R2_MAX) ? R2_MAX[R2_W-1:0] : r2_sum[R2_W-1:0];

    // z update, with zx*zy in the accumulator.
    assign nx_sum = SUM_W'(r_sq_x) - SUM_W'(r_sq_y) + SUM_W'(r_cx);
    assign ny_sum = (SUM_W'(prod) <<< 1) + SUM_W'(r_cy);

    assign last_iter = ({1'b0, r_count} + (COUNT_BITS+1)'(1)) == {1'b0, r_limit};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin : next_state_logic
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (r_mode && !c_far)
                        n_state = ST_PT_CY2;
                    else if (r_max_iter[COUNT_BITS-1:0] == '0)
                        n_state = ST_DONE;
                    else
                        n_state = ST_ZX2;
                end
            end
            ST_PT_CY2:  if (r_phase) n_state = ST_PT_CXQ2;
            ST_PT_CXQ2: if (r_phase) n_state = ST_PT_Q;
            ST_PT_Q:    n_state = ST_PT_QQ;
            ST_PT_QQ:   if (r_phase) n_state = ST_PT_BULB;
            ST_PT_BULB: begin
                if (!r_phase && in_cardioid)
                    n_state = ST_DONE;
                else if (r_phase)
                    n_state = ST_PT_BTEST;
            end
            ST_PT_BTEST: begin
                if (in_bulb || r_limit == '0)
                    n_state = ST_DONE;
                else
                    n_state = ST_ZX2;
            end
            ST_ZX2: if (r_phase) n_state = ST_ZY2;
            ST_ZY2: if (r_phase) n_state = ST_XY;
            ST_XY: begin
                if (!r_phase && escape)
                    n_state = ST_DONE;
                else if (r_phase)
                    n_state = ST_UPDATE;
            end
            ST_UPDATE: n_state = last_iter ? ST_DONE : ST_ZX2;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: datapath and register updates
    // ------------------------------------------------------------------
    always_comb begin : datapath_logic
        n_phase     = is_mul && !r_phase && (n_state == r_state);
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_max_iter  = r_max_iter;
        n_mode      = r_mode;
        n_zx        = r_zx;
        n_zy        = r_zy;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_limit     = r_limit;
        n_count     = r_count;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_cy2       = r_cy2;
        n_q         = r_q;
        n_qc        = r_qc;
        n_sq_x      = r_sq_x;
        n_sq_y      = r_sq_y;
        n_r2        = r_r2;
        n_escaped   = r_escaped;

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_ITER: n_max_iter = pwdata[MAX_ITER_W-1:0];
                REG_MODE:     n_mode     = pwdata[0];
                default:      n_mode     = r_mode;
            endcase
        end

        // multiplier passes
        if (is_mul) begin
            if (r_phase) begin
                n_acc = r_acc + (ACC_W'(part) << HALF_W);
            end else begin
                n_acc = ACC_W'(part);
                n_neg = op_a[Z_W-1] ^ op_b[Z_W-1];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_zx      = Z_W'(i_in_data.start_real);
                    n_zy      = Z_W'(i_in_data.start_imag);
                    n_cx      = Z_W'(i_in_data.const_real);
                    n_cy      = Z_W'(i_in_data.const_imag);
                    n_limit   = r_max_iter[COUNT_BITS-1:0];
                    n_count   = '0;
                    n_escaped = 1'b0;
                end
            end
            ST_PT_CXQ2: if (!r_phase) n_cy2 = prod;
            ST_PT_Q: begin
                n_q  = q_sum[Z_W-1:0];
                n_qc = qc_sum[Z_W-1:0];
            end
            ST_ZY2: if (!r_phase) n_sq_x = prod;
            ST_XY: begin
                if (!r_phase) begin
                    n_sq_y = prod;
                    if (escape) begin
                        n_escaped = 1'b1;
                        n_r2      = r2_sat;
                    end
                end
            end
            ST_UPDATE: begin
                n_zx    = nx_sum[Z_W-1:0];
                n_zy    = ny_sum[Z_W-1:0];
                n_count = r_count + COUNT_BITS'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_escaped) begin
                        n_out.iteration_count  = r_count;
                        n_out.escape_radius_sq = r_r2;
                    end else begin
                        // never escaped, in the set, or zero limit
                        n_out.iteration_count  = r_limit;
                        n_out.escape_radius_sq = '0;
                    end
                end
            end
            default: n_escaped = r_escaped;
        endcase
    end

    // ------------------------------------------------------------------
    // State elements
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_iter  <= MAX_ITER_RST;
            r_mode      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_max_iter  <= n_max_iter;
            r_mode      <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_zx      <= n_zx;
        r_zy      <= n_zy;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_limit   <= n_limit;
        r_count   <= n_count;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_cy2     <= n_cy2;
        r_q       <= n_q;
        r_qc      <= n_qc;
        r_sq_x    <= n_sq_x;
        r_sq_y    <= n_sq_y;
        r_r2      <= n_r2;
        r_escaped <= n_escaped;
    end

endmodule

`default_nettype wire
